// ===== rtl/acld_pkg.sv =====
// Package: types, constants and keyword tables of the ASCII command line decoder.
package acld_pkg;

  localparam int VALUE_BITS = 16;
  localparam int NUM_KW     = 12;
  localparam int PWM_BIT    = 12;
  localparam int KW_MAX_LEN = 10;

  typedef logic [7:0]            char_t;
  typedef logic [3:0]            pos_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [KW_MAX_LEN*8-1:0] kw_str_t;

  localparam char_t CH_NUL    = 8'h00;
  localparam char_t CH_TAB    = 8'h09;
  localparam char_t CH_CR     = 8'h0D;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_PLUS   = 8'h2B;
  localparam char_t CH_ZERO   = 8'h30;
  localparam char_t CH_NINE   = 8'h39;
  localparam char_t CH_LC_A   = 8'h61;
  localparam char_t CH_LC_Z   = 8'h7A;
  localparam char_t CASE_DIFF = 8'h20;

  typedef enum logic [1:0] {
    ST_OK, ST_EMPTY, ST_BAD_CMD, ST_BAD_PARAM
  } status_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_PING, CMD_START, CMD_STOP, CMD_MANUAL, CMD_AUTO, CMD_STATUS,
    CMD_TEMP, CMD_ADC, CMD_CLEAR, CMD_LED_ON, CMD_LED_OFF, CMD_LED_TOGGLE,
    CMD_SET_PWM
  } command_t;

  typedef enum logic [1:0] {
    LP_LEAD, LP_TEXT, LP_STOP_TEXT, LP_STOP_EMPTY
  } line_phase_t;

  typedef enum logic [2:0] {
    PP_PREFIX = 3'd0,
    PP_NAME   = 3'd1,
    PP_GAP    = 3'd2,
    PP_SIGN   = 3'd3,
    PP_DIGITS = 3'd4,
    PP_BAD    = 3'd6
  } pwm_phase_t;

  typedef struct packed {
    status_t  status;
    command_t command;
    value_t   value;
  } result_t;

  typedef struct packed {
    line_phase_t     line_phase;
    logic [NUM_KW:0] cands;
    pos_t            pos;
    logic [1:0]      sp_cnt;
    logic            sp_plain;
    pwm_phase_t      pwm_phase;
    value_t          acc;
    logic            ovf;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    line_phase: LP_LEAD,
    cands:      '1,
    pos:        '0,
    sp_cnt:     '0,
    sp_plain:   1'b1,
    pwm_phase:  PP_PREFIX,
    acc:        '0,
    ovf:        1'b0
  };

  // Keywords, right-justified in their slots; first character at byte len-1.
  localparam kw_str_t KW_TEXT [NUM_KW] = '{
    "PING", "START", "STOP", "MANUAL", "AUTO", "STATUS",
    "TEMP", "ADC", "CLEAR", "LED ON", "LED OFF", "LED TOGGLE"
  };
  localparam pos_t KW_LEN [NUM_KW] = '{
    4'd4, 4'd5, 4'd4, 4'd6, 4'd4, 4'd6, 4'd4, 4'd3, 4'd5, 4'd6, 4'd7, 4'd10
  };
  localparam logic [23:0] PWM_TEXT = "PWM";

  function automatic logic kw_match(input int k, input pos_t pos, input char_t c);
    pos_t idx;
    logic hit;
    idx = '0;
    hit = 1'b0;
    if (pos < KW_LEN[k]) begin
      idx = KW_LEN[k] - pos - 4'd1;
      hit = (KW_TEXT[k][{idx, 3'b000} +: 8] == c);
    end
    return hit;
  endfunction

  function automatic logic pwm_match(input pos_t pos, input char_t c);
    logic [1:0] idx;
    logic hit;
    idx = '0;
    hit = 1'b0;
    if (pos < 4'd3) begin
      idx = 2'd2 - pos[1:0];
      hit = (PWM_TEXT[{idx, 3'b000} +: 8] == c);
    end
    return hit;
  endfunction

  function automatic logic is_ws(input char_t c);
    return c inside {CH_SPACE, [CH_TAB:CH_CR]};
  endfunction

  function automatic logic is_digit(input char_t c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic char_t fold_upper(input char_t c);
    return (c inside {[CH_LC_A:CH_LC_Z]}) ? char_t'(c - CASE_DIFF) : c;
  endfunction

endpackage

// ===== rtl/acld_if.sv =====
// Interfaces: byte input channel and result channel of the command line decoder.
interface acld_in_if import acld_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t char_byte;
  logic  line_end;

  modport source (output valid, output char_byte, output line_end, input ready);
  modport sink   (input valid, input char_byte, input line_end, output ready);
endinterface

interface acld_out_if import acld_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] command;
  value_t     pwm_value;

  modport source (output valid, output status, output command, output pwm_value,
                  input ready);
  modport sink   (input valid, input status, input command, input pwm_value,
                  output ready);
endinterface

// ===== rtl/ascii_command_line_decoder.sv =====
// Top level: ASCII command line decoder with registered input and result stages.
//
// Usage notes
//  - in_ch carries one word per character: char_byte plus line_end. A word with
//    line_end set closes the line and yields exactly one result; its char_byte
//    is don't-care. Character words yield nothing.
//  - out_ch carries status, command and pwm_value (value is zero unless the
//    command is set_pwm).
//  - Order: a word is registered in the input register on acceptance and decoded
//    from there, where a line_end word may wait; its result is registered in
//    the output register, which drives out_ch.
//  - Throughput: one word per cycle while no line_end word waits on a stalled
//    out_ch, as the core updates the match/parse registers once per word.
//  - A result held in the output register does not block character words; only
//    a following line_end word waits while out_ch is stalled, and in_ch.ready
//    drops once the input register holds that waiting word.
//  - Reset (rst_n low, synchronous) empties both stages and returns the line
//    state to "skipping leading whitespace", as after any line_end.
module ascii_command_line_decoder import acld_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  acld_in_if.sink    in_ch,
  acld_out_if.source out_ch
);

  // input stage
  logic    in_valid_r, in_valid_nxt;
  char_t   in_byte_r;
  logic    in_end_r;

  // result stage
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t core_res;

  logic    out_busy;
  logic    step;
  logic    in_take;

  // A line_end word needs a free result register; characters never wait.
  assign out_busy = out_valid_r && !out_ch.ready;
  assign step     = in_valid_r && !(in_end_r && out_busy);
  assign in_ch.ready = !in_valid_r || step;
  assign in_take  = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take)   in_valid_nxt = 1'b1;
    else if (step) in_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step && in_end_r) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  acld_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .char_byte (in_byte_r),
    .line_end  (in_end_r),
    .result    (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.char_byte;
      in_end_r  <= in_ch.line_end;
    end
    if (step && in_end_r) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_res_r.status;
  assign out_ch.command   = out_res_r.command;
  assign out_ch.pwm_value = out_res_r.value;

endmodule

// ===== rtl/acld_core.sv =====
// Decoder core: per-line match/parse state and its update for each accepted word.
module acld_core import acld_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  char_t   char_byte,
  input  logic    line_end,
  output result_t result
);

  dec_state_t state_r, state_nxt;
  dec_state_t mid;

  function automatic pos_t sat_inc(input pos_t p);
    return (p == '1) ? p : pos_t'(p + 4'd1);
  endfunction

  function automatic dec_state_t commit_space(input dec_state_t s);
    dec_state_t n;
    logic single;
    n = s;
    single = (s.sp_cnt == 2'd1) && s.sp_plain;
    for (int k = 0; k < NUM_KW; k++) begin
      if (s.cands[k] && !(single && kw_match(k, s.pos, CH_SPACE))) n.cands[k] = 1'b0;
    end
    if (s.cands[PWM_BIT]) begin
      case (s.pwm_phase)
        PP_PREFIX: n.cands[PWM_BIT] = 1'b0;
        PP_NAME:   n.pwm_phase = PP_GAP;
        PP_GAP:    n.pwm_phase = PP_GAP;
        default:   n.pwm_phase = PP_BAD;
      endcase
    end
    n.pos = sat_inc(s.pos);
    return n;
  endfunction

  function automatic dec_state_t commit_char(input dec_state_t s, input char_t c);
    dec_state_t n;
    logic [3:0] d;
    logic [VALUE_BITS+3:0] v;
    n = s;
    d = c[3:0];
    v = ({4'b0000, s.acc} << 3) + ({4'b0000, s.acc} << 1) + {{VALUE_BITS{1'b0}}, d};
    for (int k = 0; k < NUM_KW; k++) begin
      if (s.cands[k] && !kw_match(k, s.pos, c)) n.cands[k] = 1'b0;
    end
    if (s.cands[PWM_BIT]) begin
      case (s.pwm_phase)
        PP_PREFIX: begin
          if (pwm_match(s.pos, c)) begin
            if (s.pos == 4'd2) n.pwm_phase = PP_NAME;
          end else begin
            n.cands[PWM_BIT] = 1'b0;
          end
        end
        PP_NAME: n.cands[PWM_BIT] = 1'b0;
        PP_GAP, PP_SIGN: begin
          if (is_digit(c)) begin
            n.acc       = {{(VALUE_BITS-4){1'b0}}, d};
            n.pwm_phase = PP_DIGITS;
          end else if (c == CH_PLUS && s.pwm_phase == PP_GAP) begin
            n.pwm_phase = PP_SIGN;
          end else begin
            n.pwm_phase = PP_BAD;
          end
        end
        PP_DIGITS: begin
          if (is_digit(c)) begin
            if (!s.ovf) begin
              if (|v[VALUE_BITS+3:VALUE_BITS]) n.ovf = 1'b1;
              else n.acc = v[VALUE_BITS-1:0];
            end
          end else begin
            n.pwm_phase = PP_BAD;
          end
        end
        default: n.pwm_phase = PP_BAD;
      endcase
    end
    n.pos = sat_inc(s.pos);
    return n;
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    mid       = state_r;
    if (step) begin
      if (line_end) begin
        state_nxt = STATE_RESET;
      end else if (state_r.line_phase == LP_STOP_TEXT ||
                   state_r.line_phase == LP_STOP_EMPTY) begin
        state_nxt = state_r;
      end else if (char_byte == CH_NUL) begin
        state_nxt.line_phase = (state_r.line_phase == LP_LEAD) ? LP_STOP_EMPTY : LP_STOP_TEXT;
      end else if (is_ws(char_byte)) begin
        if (state_r.line_phase == LP_TEXT) begin
          if (state_r.sp_cnt != 2'd2) state_nxt.sp_cnt = state_r.sp_cnt + 2'd1;
          if (char_byte != CH_SPACE) state_nxt.sp_plain = 1'b0;
        end
      end else begin
        if (state_r.line_phase == LP_TEXT && state_r.sp_cnt != 2'd0) begin
          mid = commit_space(state_r);
        end
        mid.sp_cnt     = 2'd0;
        mid.sp_plain   = 1'b1;
        mid.line_phase = LP_TEXT;
        state_nxt = commit_char(mid, fold_upper(char_byte));
      end
    end
  end

  // line verdict, valid when the current word ends the line
  always_comb begin
    result.status  = ST_BAD_CMD;
    result.command = CMD_NONE;
    result.value   = '0;
    if (state_r.line_phase == LP_LEAD || state_r.line_phase == LP_STOP_EMPTY) begin
      result.status = ST_EMPTY;
    end else begin
      for (int k = 0; k < NUM_KW; k++) begin
        if (state_r.cands[k] && state_r.pos == KW_LEN[k]) begin
          result.status  = ST_OK;
          result.command = command_t'(4'(k + 1));
        end
      end
      if (result.status != ST_OK && state_r.cands[PWM_BIT] &&
          state_r.pwm_phase != PP_PREFIX) begin
        if (state_r.pwm_phase == PP_DIGITS && !state_r.ovf) begin
          result.status  = ST_OK;
          result.command = CMD_SET_PWM;
          result.value   = state_r.acc;
        end else begin
          result.status = ST_BAD_PARAM;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= STATE_RESET;
    else        state_r <= state_nxt;
  end

endmodule

// ===== bench/testbench.sv =====
// Testbench for ascii_command_line_decoder: directed and random lines against a local model.
`timescale 1ns / 100ps

module testbench;
  import acld_pkg::*;

  // Directed table row: typed expectation (used only when 'typed' is set) and
  // where a NUL byte is slipped into the text (NO_NUL for none).
  typedef struct packed {
    logic       typed;
    logic [7:0] nul_at;
    status_t    st;
    command_t   cmd;
    value_t     val;
  } dir_row_t;

  localparam logic [7:0] NO_NUL   = 8'hFF;
  localparam int         DIR_ROWS = 29;
  localparam longint unsigned VALUE_LIMIT = (64'd1 << VALUE_BITS) - 64'd1;

  logic clk = 1'b0;
  logic rst_n;

  acld_in_if  in_ch ();
  acld_out_if out_ch ();

  ascii_command_line_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Keyword list, in command code order (code = index + 1).
  string keyword_text [12] = '{
    "PING", "START", "STOP", "MANUAL", "AUTO", "STATUS",
    "TEMP", "ADC", "CLEAR", "LED ON", "LED OFF", "LED TOGGLE"
  };
  string pwm_prefix = "PWM";

  // Directed lines. Only the obvious outcomes are typed in; the rest go to
  // the decoder model.
  string dir_text [DIR_ROWS] = '{
    "",
    " \t\r\n\013\014  ",
    "PING",
    "ping",
    "  Start",
    "STOP \t ",
    "manual",
    "Auto",
    "status",
    "TeMp",
    "adc",
    "clear",
    "led on",
    "LED OFF",
    "\tled toggle\r",
    "LED  ON",
    "LED\tOFF",
    "PWM 65535",
    "pwm\t+0",
    "PWM 65536",
    "PWM -5",
    "PWM +",
    "PWM",
    "PWM5",
    "PWM 1 2",
    "STOPjunk",
    "\200\377",
    "LED TOGGLE TOGGLE TOGGLE",
    "PWM 0000000000065535"
  };
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b1, NO_NUL, ST_EMPTY,     CMD_NONE,    16'd0},     // empty line
    '{1'b1, NO_NUL, ST_EMPTY,     CMD_NONE,    16'd0},     // blanks only
    '{1'b1, 8'd0,   ST_EMPTY,     CMD_NONE,    16'd0},     // NUL before any text
    '{1'b0, NO_NUL, ST_OK,        CMD_NONE,    16'd0},
    '{1'b0, NO_NUL, ST_OK,        CMD_NONE,    16'd0},
    '{1'b0, NO_NUL, ST_OK,        CMD_NONE,    16'd0},
    '{1'b0, NO_NUL, ST_OK,        CMD_NONE,    16'd0},
    '{1'b0, NO_NUL, ST_OK,        CMD_NONE,    16'd0},
    '{1'b0, NO_NUL, ST_OK,        CMD_NONE,    16'd0},
    '{1'b0, NO_NUL, ST_OK,        CMD_NONE,    16'd0},
    '{1'b0, NO_NUL, ST_OK,        CMD_NONE,    16'd0},
    '{1'b0, NO_NUL, ST_OK,        CMD_NONE,    16'd0},
    '{1'b0, NO_NUL, ST_OK,        CMD_NONE,    16'd0},
    '{1'b0, NO_NUL, ST_OK,        CMD_NONE,    16'd0},
    '{1'b0, NO_NUL, ST_OK,        CMD_NONE,    16'd0},
    '{1'b1, NO_NUL, ST_BAD_CMD,   CMD_NONE,    16'd0},     // double inner space
    '{1'b1, NO_NUL, ST_BAD_CMD,   CMD_NONE,    16'd0},     // tab as inner space
    '{1'b1, NO_NUL, ST_OK,        CMD_SET_PWM, 16'd65535}, // top value
    '{1'b1, NO_NUL, ST_OK,        CMD_SET_PWM, 16'd0},     // plus sign, zero
    '{1'b1, NO_NUL, ST_BAD_PARAM, CMD_NONE,    16'd0},     // one past the top
    '{1'b1, NO_NUL, ST_BAD_PARAM, CMD_NONE,    16'd0},     // minus sign
    '{1'b1, NO_NUL, ST_BAD_PARAM, CMD_NONE,    16'd0},     // lone plus
    '{1'b1, NO_NUL, ST_BAD_PARAM, CMD_NONE,    16'd0},     // no value at all
    '{1'b1, NO_NUL, ST_BAD_CMD,   CMD_NONE,    16'd0},     // value glued on
    '{1'b1, NO_NUL, ST_BAD_PARAM, CMD_NONE,    16'd0},     // blank inside digits
    '{1'b0, 8'd4,   ST_OK,        CMD_NONE,    16'd0},     // NUL cuts off junk
    '{1'b1, NO_NUL, ST_BAD_CMD,   CMD_NONE,    16'd0},     // top-bit bytes
    '{1'b0, NO_NUL, ST_OK,        CMD_NONE,    16'd0},     // position saturates
    '{1'b1, NO_NUL, ST_OK,        CMD_SET_PWM, 16'd65535}  // leading zeros
  };

  // Decoder model state
  line_phase_t     cur_phase;
  logic [NUM_KW:0] cur_cands;
  pos_t            cur_pos;
  logic [1:0]      blank_count;
  logic            blank_plain;
  pwm_phase_t      param_phase;
  longint unsigned param_acc;
  logic            param_ovf;

  result_t pending_results [$];
  result_t want;
  int      mismatch_count = 0;
  int      words_sent = 0;
  logic    steady = 1'b0;   // no idling on either side while set

  function automatic void clear_line();
    cur_phase   = LP_LEAD;
    cur_cands   = '1;
    cur_pos     = '0;
    blank_count = '0;
    blank_plain = 1'b1;
    param_phase = PP_PREFIX;
    param_acc   = 0;
    param_ovf   = 1'b0;
  endfunction

  // Advance the decoder model by one word; returns 1 when the word closes
  // the line, with the line's outcome in res.
  function automatic logic decode_word(input char_t ch, input logic le,
                                       output result_t res);
    char_t           c;
    logic            single;
    longint unsigned nxt;
    res = '{ST_BAD_CMD, CMD_NONE, '0};
    if (!le) begin
      if (cur_phase == LP_STOP_TEXT || cur_phase == LP_STOP_EMPTY) return 1'b0;
      if (ch == CH_NUL) begin
        cur_phase = (cur_phase == LP_LEAD) ? LP_STOP_EMPTY : LP_STOP_TEXT;
        return 1'b0;
      end
      if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
        // blanks are only held back once text has started
        if (cur_phase == LP_TEXT) begin
          if (blank_count < 2'd2) blank_count++;
          if (ch != CH_SPACE) blank_plain = 1'b0;
        end
        return 1'b0;
      end
      c = (ch >= CH_LC_A && ch <= CH_LC_Z) ? char_t'(ch - CASE_DIFF) : ch;

      // held-back blanks count as one keyword space only if a single 0x20
      if (cur_phase == LP_TEXT && blank_count != 2'd0) begin
        single = (blank_count == 2'd1) && blank_plain;
        for (int k = 0; k < NUM_KW; k++)
          if (cur_cands[k] && !(single && cur_pos < keyword_text[k].len() &&
                                keyword_text[k][cur_pos] == CH_SPACE))
            cur_cands[k] = 1'b0;
        if (cur_cands[PWM_BIT]) begin
          case (param_phase)
            PP_PREFIX: cur_cands[PWM_BIT] = 1'b0;
            PP_NAME:   param_phase = PP_GAP;
            PP_GAP:    ;
            default:   param_phase = PP_BAD;
          endcase
        end
        if (cur_pos != 4'd15) cur_pos++;
      end
      blank_count = '0;
      blank_plain = 1'b1;
      cur_phase   = LP_TEXT;

      for (int k = 0; k < NUM_KW; k++)
        if (cur_cands[k] && !(cur_pos < keyword_text[k].len() &&
                              keyword_text[k][cur_pos] == c))
          cur_cands[k] = 1'b0;
      if (cur_cands[PWM_BIT]) begin
        case (param_phase)
          PP_PREFIX: begin
            if (cur_pos < 4'd3 && pwm_prefix[cur_pos] == c) begin
              if (cur_pos == 4'd2) param_phase = PP_NAME;
            end else begin
              cur_cands[PWM_BIT] = 1'b0;
            end
          end
          PP_NAME: cur_cands[PWM_BIT] = 1'b0;   // value glued to the name
          PP_GAP, PP_SIGN: begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
              param_acc   = c - CH_ZERO;
              param_phase = PP_DIGITS;
            end else if (c == CH_PLUS && param_phase == PP_GAP) begin
              param_phase = PP_SIGN;
            end else begin
              param_phase = PP_BAD;
            end
          end
          PP_DIGITS: begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
              if (!param_ovf) begin
                nxt = param_acc * 10 + (c - CH_ZERO);
                if (nxt > VALUE_LIMIT) param_ovf = 1'b1;
                else param_acc = nxt;
              end
            end else begin
              param_phase = PP_BAD;
            end
          end
          default: param_phase = PP_BAD;
        endcase
      end
      if (cur_pos != 4'd15) cur_pos++;
      return 1'b0;
    end

    // end of line
    if (cur_phase == LP_LEAD || cur_phase == LP_STOP_EMPTY) begin
      res.status = ST_EMPTY;
    end else begin
      for (int k = 0; k < NUM_KW; k++)
        if (cur_cands[k] && cur_pos == keyword_text[k].len()) begin
          res.status  = ST_OK;
          res.command = command_t'(k + 1);
        end
      if (res.status != ST_OK && cur_cands[PWM_BIT] && param_phase != PP_PREFIX) begin
        if (param_phase == PP_DIGITS && !param_ovf) begin
          res.status  = ST_OK;
          res.command = CMD_SET_PWM;
          res.value   = param_acc[VALUE_BITS-1:0];
        end else begin
          res.status = ST_BAD_PARAM;
        end
      end
    end
    clear_line();
    return 1'b1;
  endfunction

  // One word on in_ch; waits for the handshake, then runs the model.
  task automatic send_word(input char_t ch, input logic le, input logic typed,
                           input result_t typed_res);
    result_t predicted;
    while (!steady && $urandom_range(0, 99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_byte <= ch;
    in_ch.line_end  <= le;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    if (decode_word(ch, le, predicted))
      pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // A whole line, closed by a line_end word carrying a random byte.
  task automatic send_line(input char_t bytes [$], input logic typed,
                           input result_t typed_res);
    foreach (bytes[i]) send_word(bytes[i], 1'b0, 1'b0, '0);
    send_word(char_t'($urandom_range(0, 255)), 1'b1, typed, typed_res);
  endtask

  // Mostly plain spaces, now and then another blank.
  function automatic char_t pick_blank();
    case ($urandom_range(0, 9))
      0:       return CH_TAB;
      1:       return char_t'($urandom_range(8'h0A, 8'h0C));
      2:       return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic char_t vary_case(input char_t c);
    if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) return char_t'(c + CASE_DIFF);
    return c;
  endfunction

  // Sink side: random back-pressure and result checking.
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 12);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result status=%0d command=%0d value=%0d", $time,
                 out_ch.status, out_ch.command, out_ch.pwm_value);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          mismatch_count++;
          $display("%0t: status expected %0d got %0d", $time, want.status,
                   out_ch.status);
        end
        if (out_ch.command !== want.command) begin
          mismatch_count++;
          $display("%0t: command expected %0d got %0d", $time, want.command,
                   out_ch.command);
        end
        if (out_ch.pwm_value !== want.value) begin
          mismatch_count++;
          $display("%0t: pwm_value expected %0d got %0d", $time, want.value,
                   out_ch.pwm_value);
        end
      end
    end
  end

  // Stimulus
  initial begin
    char_t           line_q [$];
    string           digits;
    int              kind;
    int              kw;
    longint unsigned num;
    dir_row_t        row;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.char_byte <= '0;
    in_ch.line_end  <= 1'b0;
    clear_line();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_rows[r];
      line_q.delete();
      for (int i = 0; i < dir_text[r].len(); i++) begin
        if (i == row.nul_at) line_q.push_back(CH_NUL);
        line_q.push_back(dir_text[r][i]);
      end
      if (row.nul_at == dir_text[r].len()) line_q.push_back(CH_NUL);
      send_line(line_q, row.typed, '{row.st, row.cmd, row.val});
    end

    // random lines: mostly well-formed keywords and PWM lines with random
    // content, the rest noise, broken spacing and NUL-cut lines
    while (words_sent < 1950) begin
      steady = (words_sent > 800 && words_sent < 1150);
      line_q.delete();
      repeat ($urandom_range(0, 2)) line_q.push_back(pick_blank());
      kind = $urandom_range(0, 99);
      if (kind < 38) begin
        kw = $urandom_range(0, NUM_KW - 1);
        for (int i = 0; i < keyword_text[kw].len(); i++) begin
          if (keyword_text[kw][i] == CH_SPACE && $urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 2)) line_q.push_back(pick_blank());
          else
            line_q.push_back(vary_case(keyword_text[kw][i]));
        end
        case ($urandom_range(0, 19))
          0:       void'(line_q.pop_back());
          1:       line_q.push_back(char_t'($urandom_range("A", "Z")));
          2:       line_q.push_front(vary_case(char_t'($urandom_range("A", "Z"))));
          default: ;
        endcase
      end else if (kind < 75) begin
        for (int i = 0; i < 3; i++) line_q.push_back(vary_case(pwm_prefix[i]));
        if ($urandom_range(0, 9) != 0)
          repeat ($urandom_range(1, 3)) line_q.push_back(pick_blank());
        case ($urandom_range(0, 24))
          0, 1:    line_q.push_back(CH_PLUS);
          2:       line_q.push_back("-");
          default: ;
        endcase
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
          line_q.push_back(CH_ZERO);
        case ($urandom_range(0, 19))
          0, 1, 2: num = $urandom_range(65530, 65540);
          3, 4, 5: num = $urandom_range(0, 99);
          6, 7:    num = $urandom_range(0, 9999999);
          default: num = $urandom_range(0, 65535);
        endcase
        if ($urandom_range(0, 11) != 0) begin
          digits = $sformatf("%0d", num);
          for (int i = 0; i < digits.len(); i++) line_q.push_back(digits[i]);
        end
        case ($urandom_range(0, 24))
          0:       line_q.push_back(char_t'($urandom_range(0, 255)));
          1: begin
            line_q.push_back(CH_SPACE);
            line_q.push_back(char_t'($urandom_range(CH_ZERO, CH_NINE)));
          end
          default: ;
        endcase
      end else if (kind < 88) begin
        repeat ($urandom_range(0, 20)) line_q.push_back(char_t'($urandom_range(0, 255)));
      end else begin
        kw = $urandom_range(0, NUM_KW - 1);
        for (int i = 0; i < keyword_text[kw].len(); i++)
          line_q.push_back(vary_case(keyword_text[kw][i]));
        line_q.insert($urandom_range(0, line_q.size()), CH_NUL);
        repeat ($urandom_range(0, 4)) line_q.push_back(char_t'($urandom_range(0, 255)));
      end
      repeat ($urandom_range(0, 2)) line_q.push_back(pick_blank());
      send_line(line_q, 1'b0, '0);
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    // drain, then keep the clock running for anything stray
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ascii_command_line_decoder verification clean");
    end else begin
      $display("ascii_command_line_decoder verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("ascii_command_line_decoder verification failed");
    $finish;
  end

endmodule
